// File: src/tfct_pkg.sv
// package for the fall-confirm track table
// types, sizes and codes shared by the table ram, the time compare unit and the top level
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tfct_pkg;

   localparam int TRACK_SLOTS = 32;
   localparam int SLOT_W      = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
   localparam int CNT_W       = $clog2(TRACK_SLOTS + 1);
   localparam int TIME_W      = 32;
   localparam int ID_W        = 17;
   localparam int TRACK_W     = 16;
   localparam int CSR_IDX_W   = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_CONFIRM_TIME  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STALE_TIMEOUT = 2'd1;

   localparam logic [TIME_W-1:0] CONFIRM_TIME_RESET  = 32'd2000;
   localparam logic [TIME_W-1:0] STALE_TIMEOUT_RESET = 32'd5000;

   localparam logic       KIND_DETECT = 1'b0;
   localparam logic       KIND_SWEEP  = 1'b1;
   localparam logic [1:0] CLS_PERSON  = 2'd1;
   localparam logic [1:0] CLS_DOWN    = 2'd2;

   typedef struct packed {
      logic [TRACK_W-1:0] track;
      logic               in_down;
      logic               confirmed;
      logic [TIME_W-1:0]  down_start;
      logic [TIME_W-1:0]  last_seen;
   } entry_type;

   typedef struct packed {
      logic [TIME_W-1:0] a;
      logic [TIME_W-1:0] b;
      logic [TIME_W-1:0] limit;
      logic              incl;
   } cmp_req_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_APPLY,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// File: src/tfct_entry_ram.sv
// per-slot track entry storage, one write and one registered read port
// depends on tfct_pkg
`timescale 1ns / 1ps
`default_nettype none

module tfct_entry_ram (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [tfct_pkg::SLOT_W-1:0] wr_addr,
   input  wire tfct_pkg::entry_type        wr_data,
   input  wire logic [tfct_pkg::SLOT_W-1:0] rd_addr,
   output tfct_pkg::entry_type             rd_data
);

   tfct_pkg::entry_type mem [tfct_pkg::TRACK_SLOTS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// File: src/tfct_time_cmp.sv
// shared wrapping time difference and threshold compare
// used for the stale check during sweeps and the confirm check on down detections
// depends on tfct_pkg
`timescale 1ns / 1ps
`default_nettype none

module tfct_time_cmp (
   input  wire tfct_pkg::cmp_req_type req,
   output logic                       over
);

   logic [tfct_pkg::TIME_W-1:0] diff;

   always_comb begin
      diff = req.a - req.b;
      if (req.incl) begin
         over = (diff >= req.limit);
      end else begin
         over = (diff > req.limit);
      end
   end

endmodule

`default_nettype wire

// File: src/track_fall_confirm_table.sv
// Fall-confirm track table, top level.
// Channels: req_* carries one transaction per detection or sweep (valid/stall),
// rsp_* returns one result per request (valid/stall), csr_* writes the confirm
// time (index 0) and the stale timeout (index 1); csr_ready is always high and
// writes are expected only while the block is idle.
// A tracked person or down detection and a sweep scan all TRACK_SLOTS entries
// of the entry ram one per cycle through its single read port. A detection
// then passes the drain and apply states before done, a sweep only drain; an
// untracked or other-class detection goes straight to done without a scan.
// req_stall stays high while a request is in flight
// and drops the cycle after the result loads.
// The result sits in an output register, so a new request is taken while the
// previous result waits; if rsp_stall holds the old result when the next one is
// finished, the block waits in its final state until the register frees up.
// Synchronous reset clears all valid bits, the track count, the handshakes and
// restores the register defaults (2000 ms confirm, 5000 ms timeout).
// Depends on tfct_pkg, tfct_entry_ram and tfct_time_cmp.
`timescale 1ns / 1ps
`default_nettype none

module track_fall_confirm_table (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_kind,
   input  wire logic signed [16:0]            req_track_id,
   input  wire logic [1:0]                    req_class_kind,
   input  wire logic [31:0]                   req_timestamp_ms,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [16:0]                 rsp_id_echo,
   output logic                               rsp_fall_confirmed,
   output logic                               rsp_table_full,
   output logic [5:0]                         rsp_active_tracks,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [tfct_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]                   csr_wdata
);

   localparam int SW = tfct_pkg::SLOT_W;
   localparam int CW = tfct_pkg::CNT_W;
   localparam logic [SW-1:0] LAST_SLOT = SW'(tfct_pkg::TRACK_SLOTS - 1);

   tfct_pkg::state_type state_ff, state_in;

   logic [31:0] confirm_ff, stale_ff;

   logic        kind_ff;
   logic [16:0] id_ff;
   logic [1:0]  cls_ff;
   logic [31:0] now_ff;

   logic [tfct_pkg::TRACK_SLOTS-1:0] valid_ff, valid_in;
   logic [CW-1:0]                    count_ff, count_in;

   logic [SW-1:0] idx_ff, chk_idx_ff;
   logic          chk_vld_ff;

   logic                hit_ff, hit_in, free_ff, free_in;
   logic [SW-1:0]       hit_idx_ff, hit_idx_in, free_idx_ff, free_idx_in;
   tfct_pkg::entry_type hit_ent_ff, hit_ent_in;
   logic                fall_ff, fall_in, full_ff, full_in;

   logic        rsp_valid_ff;
   logic [16:0] rsp_id_ff;
   logic        rsp_fall_ff, rsp_full_ff;
   logic [5:0]  rsp_cnt_ff;

   // fsm outputs
   logic scan_en, apply_en, done_load, rsp_free, accept, needs_scan;

   // ram and compare unit
   logic                  wr_en;
   logic [SW-1:0]         wr_addr;
   tfct_pkg::entry_type   wr_data, rd_data;
   tfct_pkg::cmp_req_type cmp_req;
   logic                  cmp_over;

   logic [31:0]    ds_sel;
   logic           conf_new, chk_bit, sweep_clear;
   logic [CW+5:0]  cnt_ext;

   tfct_entry_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   tfct_time_cmp u_cmp (
      .req  (cmp_req),
      .over (cmp_over)
   );

   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign accept     = req_valid && !req_stall;
   assign needs_scan = (req_kind == tfct_pkg::KIND_SWEEP) ||
                       (!req_track_id[16] && ((req_class_kind == tfct_pkg::CLS_PERSON) ||
                                              (req_class_kind == tfct_pkg::CLS_DOWN)));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tfct_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = needs_scan ? tfct_pkg::ST_SCAN : tfct_pkg::ST_DONE;
            end
         end
         tfct_pkg::ST_SCAN: begin
            if (idx_ff == LAST_SLOT) begin
               state_in = tfct_pkg::ST_DRAIN;
            end
         end
         tfct_pkg::ST_DRAIN: begin
            state_in = (kind_ff == tfct_pkg::KIND_SWEEP) ? tfct_pkg::ST_DONE
                                                        : tfct_pkg::ST_APPLY;
         end
         tfct_pkg::ST_APPLY: state_in = tfct_pkg::ST_DONE;
         tfct_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = tfct_pkg::ST_IDLE;
            end
         end
         default: state_in = tfct_pkg::ST_IDLE;
      endcase
   end

   // fsm outputs
   always_comb begin
      req_stall = 1'b1;
      scan_en   = 1'b0;
      apply_en  = 1'b0;
      done_load = 1'b0;
      unique case (state_ff)
         tfct_pkg::ST_IDLE:  req_stall = 1'b0;
         tfct_pkg::ST_SCAN:  scan_en   = 1'b1;
         tfct_pkg::ST_DRAIN: ;
         tfct_pkg::ST_APPLY: apply_en  = 1'b1;
         tfct_pkg::ST_DONE:  done_load = rsp_free;
         default: ;
      endcase
   end

   // shared compare: confirm check while applying, stale check otherwise
   assign ds_sel = hit_ent_ff.in_down ? hit_ent_ff.down_start : now_ff;
   always_comb begin
      if (apply_en) begin
         cmp_req = '{a: now_ff, b: ds_sel, limit: confirm_ff, incl: 1'b1};
      end else begin
         cmp_req = '{a: now_ff, b: rd_data.last_seen, limit: stale_ff, incl: 1'b0};
      end
   end
   assign conf_new = (hit_ent_ff.in_down & hit_ent_ff.confirmed) | cmp_over;

   assign chk_bit     = valid_ff[chk_idx_ff];
   assign sweep_clear = chk_vld_ff && (kind_ff == tfct_pkg::KIND_SWEEP) && chk_bit && cmp_over;

   // scan results, table update and flags
   always_comb begin
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_ent_in  = hit_ent_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      fall_in     = fall_ff;
      full_in     = full_ff;
      valid_in    = valid_ff;
      count_in    = count_ff;
      wr_en       = 1'b0;
      wr_addr     = hit_idx_ff;
      wr_data     = hit_ent_ff;

      if (accept) begin
         hit_in  = 1'b0;
         free_in = 1'b0;
         fall_in = 1'b0;
         full_in = 1'b0;
      end

      if (chk_vld_ff && (kind_ff == tfct_pkg::KIND_DETECT)) begin
         if (chk_bit && (rd_data.track == id_ff[15:0]) && !hit_ff) begin
            hit_in     = 1'b1;
            hit_idx_in = chk_idx_ff;
            hit_ent_in = rd_data;
         end
         if (!chk_bit && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = chk_idx_ff;
         end
      end

      if (sweep_clear) begin
         valid_in[chk_idx_ff] = 1'b0;
         count_in             = count_ff - CW'(1);
      end

      if (apply_en) begin
         if (cls_ff == tfct_pkg::CLS_PERSON) begin
            if (hit_ff) begin
               wr_en           = 1'b1;
               wr_data.in_down = 1'b0;
               wr_data.last_seen = now_ff;
               if (hit_ent_ff.in_down) begin
                  wr_data.confirmed  = 1'b0;
                  wr_data.down_start = '0;
               end
            end else if (free_ff) begin
               wr_en                 = 1'b1;
               wr_addr               = free_idx_ff;
               wr_data               = '{track: id_ff[15:0], in_down: 1'b0, confirmed: 1'b0,
                                         down_start: '0, last_seen: now_ff};
               valid_in[free_idx_ff] = 1'b1;
               count_in              = count_ff + CW'(1);
            end else begin
               full_in = 1'b1;
            end
         end else if (hit_ff) begin
            wr_en              = 1'b1;
            wr_data.in_down    = 1'b1;
            wr_data.confirmed  = conf_new;
            wr_data.down_start = ds_sel;
            wr_data.last_seen  = now_ff;
            fall_in            = conf_new;
         end
      end
   end

   assign cnt_ext = {6'd0, count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tfct_pkg::ST_IDLE;
         confirm_ff   <= tfct_pkg::CONFIRM_TIME_RESET;
         stale_ff     <= tfct_pkg::STALE_TIMEOUT_RESET;
         valid_ff     <= '0;
         count_ff     <= '0;
         chk_vld_ff   <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         count_ff   <= count_in;
         chk_vld_ff <= scan_en;
         if (accept) begin
            idx_ff <= '0;
         end else if (scan_en) begin
            idx_ff <= idx_ff + SW'(1);
         end
         if (csr_valid) begin
            if (csr_index == tfct_pkg::CSR_CONFIRM_TIME) begin
               confirm_ff <= csr_wdata;
            end else if (csr_index == tfct_pkg::CSR_STALE_TIMEOUT) begin
               stale_ff <= csr_wdata;
            end
         end
         if (done_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      chk_idx_ff  <= idx_ff;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_ent_ff  <= hit_ent_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      fall_ff     <= fall_in;
      full_ff     <= full_in;
      if (accept) begin
         kind_ff <= req_kind;
         id_ff   <= req_track_id;
         cls_ff  <= req_class_kind;
         now_ff  <= req_timestamp_ms;
      end
      if (done_load) begin
         rsp_id_ff   <= (kind_ff == tfct_pkg::KIND_SWEEP) ? '1 : id_ff;
         rsp_fall_ff <= fall_ff;
         rsp_full_ff <= full_ff;
         rsp_cnt_ff  <= cnt_ext[5:0];
      end
   end

   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_id_echo        = rsp_id_ff;
   assign rsp_fall_confirmed = rsp_fall_ff;
   assign rsp_table_full     = rsp_full_ff;
   assign rsp_active_tracks  = rsp_cnt_ff;

`ifndef SYNTH
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      count_ff == CW'($countones(valid_ff)))
      else $error("track count out of step with valid bits");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == tfct_pkg::ST_DONE))
      else $error("result raised outside the done state");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("request taken while a transaction is in flight");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_full_ff && rsp_fall_ff))
      else $error("table full and fall confirmed on one result");
`endif

endmodule

`default_nettype wire
